>>> sv/rbf_pkg.sv
// Shared types and constants for the bit receiver framer.
// Holds the configuration, per-bit state and result record layouts.
// No dependencies; every other file in the block imports this package.
package rbf_pkg;

  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned RING_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [6:0] BIT_CNT_MAX = 7'h7F;
  localparam logic [6:0] BITS_PER_BYTE = 7'd8;
  localparam logic [8:0] BYTE_SYNC1  = 9'd0;
  localparam logic [8:0] BYTE_SYNC2  = 9'd1;
  localparam logic [8:0] BYTE_ADDR   = 9'd2;
  localparam logic [8:0] BYTE_LENGTH = 9'd3;
  localparam logic [9:0] HEADER_BYTES = 10'd4;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_LOCKED     = 3'd1,
    ST_PRE_BROKEN = 3'd2,
    ST_SYNC1_BAD  = 3'd3,
    ST_SYNC2_BAD  = 3'd4,
    ST_ADDR_BAD   = 3'd5,
    ST_LEN_BAD    = 3'd6,
    ST_FRAME_DONE = 3'd7
  } rbf_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_ONE     = 3'd0,
    CFG_SYNC_TWO     = 3'd1,
    CFG_OWN_ADDRESS  = 3'd2,
    CFG_PREAMBLE     = 3'd3,
    CFG_MAX_PAYLOAD  = 3'd4
  } rbf_cfg_idx_e;

  typedef struct packed {
    logic [7:0] sync_byte_one;
    logic [7:0] sync_byte_two;
    logic [7:0] own_address;
    logic [3:0] preamble_bytes;
    logic [7:0] max_payload;
  } rbf_cfg_t;

  typedef struct packed {
    logic              mode_receive;
    logic              expect_one;
    logic              preamble_finished;
    logic [6:0]        bit_count;
    logic [8:0]        byte_count;
    logic [7:0]        shift_byte;
    logic [7:0]        frame_length;
    logic [RING_W-1:0] ring_pos;
  } rbf_state_t;

  // Packed from the status field in the low bits upwards.
  typedef struct packed {
    logic        receiving;
    logic [5:0]  write_index;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    rbf_status_e status;
  } rbf_result_t;

  localparam int unsigned RESULT_W = $bits(rbf_result_t);

endpackage

>>> sv/rbf_cfg_regs.sv
// Configuration register file for the bit receiver framer.
// Depends on rbf_pkg for the register layout and index codes.
module rbf_cfg_regs
  import rbf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output rbf_cfg_t              cfg_o
);

  rbf_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SYNC_ONE:    cfg_d.sync_byte_one  = cfg_data_i;
        CFG_SYNC_TWO:    cfg_d.sync_byte_two  = cfg_data_i;
        CFG_OWN_ADDRESS: cfg_d.own_address    = cfg_data_i;
        CFG_PREAMBLE:    cfg_d.preamble_bytes = cfg_data_i[3:0];
        CFG_MAX_PAYLOAD: cfg_d.max_payload    = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_byte_one  <= 8'd0;
      cfg_q.sync_byte_two  <= 8'd0;
      cfg_q.own_address    <= 8'd0;
      cfg_q.preamble_bytes <= 4'd3;
      cfg_q.max_payload    <= 8'd64;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> sv/rbf_bit_step.sv
// Per-bit update of the framer: preamble hunt, lock, byte assembly and checks.
// Purely combinational; depends on rbf_pkg for state, config and result types.
module rbf_bit_step
  import rbf_pkg::*;
(
  input  rbf_state_t  state_i,
  input  rbf_cfg_t    cfg_i,
  input  logic        data_bit_i,
  output rbf_state_t  state_o,
  output rbf_result_t result_o
);

  always_comb begin
    rbf_state_t  nxt;
    rbf_result_t res;
    logic        take_bit;
    logic        hunt;
    logic [6:0]  cnt_sat;
    logic [6:0]  bit_inc;
    logic [7:0]  shifted;
    logic [8:0]  byte_inc;
    logic [8:0]  ring_inc;
    logic [8:0]  ring_wide;

    nxt       = state_i;
    res       = '0;
    take_bit  = 1'b0;
    hunt      = 1'b0;
    cnt_sat   = (state_i.bit_count == BIT_CNT_MAX) ? state_i.bit_count
                                                   : state_i.bit_count + 7'd1;
    bit_inc   = state_i.bit_count + 7'd1;
    shifted   = {state_i.shift_byte[6:0], data_bit_i};
    byte_inc  = state_i.byte_count + 9'd1;
    ring_inc  = 9'(state_i.ring_pos) + 9'd1;
    ring_wide = 9'(state_i.ring_pos);

    if (state_i.mode_receive) begin
      if (state_i.preamble_finished) begin
        take_bit = 1'b1;
      end else if (state_i.expect_one) begin
        if (data_bit_i) begin
          nxt.expect_one = 1'b0;
        end else begin
          // Two zeros in a row: this zero opens the data
          nxt.preamble_finished = 1'b1;
          take_bit = 1'b1;
        end
      end else if (data_bit_i) begin
        res.status = ST_PRE_BROKEN;
        hunt = 1'b1;
      end else begin
        nxt.expect_one = 1'b1;
      end
    end else begin
      if (state_i.expect_one) begin
        if (data_bit_i) begin
          nxt.expect_one = 1'b0;
          nxt.bit_count  = cnt_sat;
        end else begin
          nxt.bit_count = 7'd0;
        end
      end else begin
        nxt.expect_one = 1'b1;
        if (data_bit_i) begin
          nxt.bit_count = 7'd0;
        end else begin
          nxt.bit_count = cnt_sat;
          if (cnt_sat >= {cfg_i.preamble_bytes, 3'b000}) begin
            res.status            = ST_LOCKED;
            nxt.mode_receive      = 1'b1;
            nxt.bit_count         = 7'd0;
            nxt.byte_count        = 9'd0;
            nxt.shift_byte        = 8'd0;
            nxt.frame_length      = 8'd0;
            nxt.preamble_finished = 1'b0;
            nxt.expect_one        = 1'b1;
          end
        end
      end
    end

    if (take_bit) begin
      nxt.shift_byte = shifted;
      nxt.bit_count  = bit_inc;
      if (bit_inc == BITS_PER_BYTE) begin
        nxt.bit_count = 7'd0;
        case (state_i.byte_count)
          BYTE_SYNC1: if (shifted != cfg_i.sync_byte_one) res.status = ST_SYNC1_BAD;
          BYTE_SYNC2: if (shifted != cfg_i.sync_byte_two) res.status = ST_SYNC2_BAD;
          BYTE_ADDR:  if (shifted != cfg_i.own_address)   res.status = ST_ADDR_BAD;
          BYTE_LENGTH: begin
            nxt.frame_length = shifted;
            if (shifted > cfg_i.max_payload) begin
              nxt.frame_length = 8'd0;
              res.status = ST_LEN_BAD;
            end
          end
          default: begin
            res.byte_valid   = 1'b1;
            res.payload_byte = shifted;
            nxt.ring_pos = (ring_inc >= 9'(RING_DEPTH)) ? '0 : ring_inc[RING_W-1:0];
          end
        endcase
        nxt.byte_count = byte_inc;
        if (res.status != ST_NONE) begin
          hunt = 1'b1;
        end else if ({1'b0, byte_inc} >= {2'b00, nxt.frame_length} + HEADER_BYTES) begin
          res.status = ST_FRAME_DONE;
          hunt = 1'b1;
        end
      end
    end

    if (hunt) begin
      nxt.mode_receive      = 1'b0;
      nxt.bit_count         = 7'd0;
      nxt.byte_count        = 9'd0;
      nxt.preamble_finished = 1'b0;
      nxt.expect_one        = 1'b0;
    end

    // The ring slot only moves on a payload byte, so the old slot serves both cases
    res.write_index = ring_wide[5:0];
    res.receiving   = nxt.mode_receive;

    state_o  = nxt;
    result_o = res;
  end

endmodule

>>> sv/rbf_out_stage.sv
// Result register of the framer, with master-side stream handshake.
// Depends on rbf_pkg for the result record and tdata width.
module rbf_out_stage
  import rbf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  rbf_result_t            result_i,
  output logic                   space_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic        valid_q, valid_d;
  rbf_result_t data_q, data_d;

  assign space_o       = !valid_q || m_axis_tready;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), data_q};

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load_i) begin
      valid_d = 1'b1;
      data_d  = result_i;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

>>> sv/rf_bit_receiver_framer_core.sv
// Bit receiver framer: one data bit per beat in, one result beat out per bit.
// The result of an accepted input beat is registered and shows on the master side in the next cycle.
// Throughput: 1 bit per cycle; the only limit is the master side taking results.
// Reset (rst_ni low, asynchronous): hunting mode, all counters and the ring slot
// cleared, registers set to sync 0/0, address 0, preamble 3 bytes, max payload 64.
// Depends on rbf_pkg, rbf_cfg_regs, rbf_bit_step and rbf_out_stage.
module rf_bit_receiver_framer_core
  import rbf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // Bit stream in
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [0] data_bit, [7:1] zero
  // Result stream out
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [2:0] status, [3] byte_valid,
                                                // [11:4] payload_byte,
                                                // [17:12] write_index,
                                                // [18] receiving, [23:19] zero
);

  rbf_cfg_t    cfg;
  rbf_state_t  state_q, state_d;
  rbf_result_t step_res;
  logic        out_space;
  logic        in_beat;

  rbf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The whole per-bit update sits between the framer state and the result register
  rbf_bit_step u_step (
    .state_i    (state_q),
    .cfg_i      (cfg),
    .data_bit_i (s_axis_tdata[0]),
    .state_o    (state_d),
    .result_o   (step_res)
  );

  // Take a new bit whenever the result register is empty or being drained
  assign s_axis_tready = out_space;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // Advance the framer state only on an accepted beat; hold it otherwise
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_beat) begin
      state_q <= state_d;
    end
  end

  rbf_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (in_beat),
    .result_i      (step_res),
    .space_o       (out_space),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> sv/rbf_port_chk.sv
// Port-level checks on the framer's result stream, bound to the top level.
// Depends on rbf_pkg for widths and status codes.
module rbf_port_chk
  import rbf_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result beat holds its contents
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Lock always leaves the block receiving; errors and frame end leave it hunting
  a_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tdata[2:0] == ST_LOCKED) == m_axis_tdata[18]) ||
      (m_axis_tdata[2:0] == ST_NONE))
    else $error("mode does not match status");

  // A payload byte only comes with no status or with frame done
  a_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |->
      (m_axis_tdata[2:0] == ST_NONE) || (m_axis_tdata[2:0] == ST_FRAME_DONE))
    else $error("payload byte with error status");

  // No payload byte means a zero byte field and zero padding
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[23:19] == 5'd0) && (m_axis_tdata[3] || (m_axis_tdata[11:4] == 8'd0)))
    else $error("stray bits in result beat");

endmodule

bind rf_bit_receiver_framer_core rbf_port_chk u_rbf_port_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
